// File: rtl/core/infix_expression_evaluator_macros.svh
// Assertion macros used by the evaluator back end.
`ifndef INFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define INFIX_EXPRESSION_EVALUATOR_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define IEE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked on the next clock edge after the antecedent.
`define IEE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: rtl/core/iee_pkg.sv
// Package with the evaluator's types, codes and default sizes.
package iee_pkg;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int INT_BITS_DEF    = 32;
    localparam int VALUE_W         = 48;
    localparam int CH_W            = 8;
    localparam int STATUS_W        = 2;
    localparam int LEVEL_W         = 8;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_MALF  = 2'd1;
    localparam logic [1:0] ST_OVFL  = 2'd2;
    localparam logic [1:0] ST_DIV0  = 2'd3;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Token classes passed from the front end to the back end.
    localparam logic [2:0] TK_NUM   = 3'd0;
    localparam logic [2:0] TK_OPEN  = 3'd1;
    localparam logic [2:0] TK_CLOSE = 3'd2;
    localparam logic [2:0] TK_OPER  = 3'd3;
    localparam logic [2:0] TK_END   = 3'd4;
    localparam logic [2:0] TK_NOP   = 3'd5;

    typedef struct packed {
        logic [2:0]         kind;
        logic [1:0]         code;
        logic [VALUE_W-1:0] num;
    } token_t;
endpackage

// File: rtl/core/iee_front.sv
// Front end: digit accumulation and character classification into tokens.
module iee_front #(
    parameter int FRAC_BITS = iee_pkg::FRAC_BITS_DEF,
    parameter int INT_BITS  = iee_pkg::INT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [iee_pkg::CH_W-1:0] ch,
    input  logic                  last,
    input  logic                  in_valid,
    output logic                  in_stall,
    output iee_pkg::token_t       tok,
    output logic                  tok_valid,
    input  logic                  tok_stall
);
    import iee_pkg::*;

    localparam int VB = (INT_BITS + FRAC_BITS > VALUE_W) ? VALUE_W : INT_BITS + FRAC_BITS;
    localparam logic [VALUE_W:0] VMAX = ({{VALUE_W{1'b0}}, 1'b1} << (VB - 1)) - 1'b1;

    // An item queues up to two tokens: the finished number, then its own or the end marker.
    logic [VALUE_W-1:0] pend_reg, pend_next;
    logic               act_reg, act_next;
    token_t             q_reg [2];
    token_t             q_next [2];
    logic [1:0]         cnt_reg, cnt_next;
    logic               hd_reg, hd_next;
    logic               end_reg, end_next;

    logic               digit;
    logic [VALUE_W+4:0] acc;
    logic [VALUE_W-1:0] dig_val;
    token_t             own;
    logic               has_own;

    assign digit    = (ch >= CH_ZERO) && (ch <= CH_NINE);
    // Hold the input while tokens are queued or an end marker is still owed.
    assign in_stall = (cnt_reg != 2'd0) || end_reg;
    assign tok      = q_reg[hd_reg];
    assign tok_valid = (cnt_reg != 2'd0);

    always_comb
    begin
        dig_val = VALUE_W'(ch - CH_ZERO) << FRAC_BITS;
        acc = ({5'd0, pend_reg} << 3) + ({5'd0, pend_reg} << 1) + {5'd0, dig_val};
        own = '{kind: TK_NOP, code: OP_ADD, num: '0};
        has_own = 1'b0;
        unique case (ch)
            CH_OPEN:  begin own.kind = TK_OPEN;  has_own = 1'b1; end
            CH_CLOSE: begin own.kind = TK_CLOSE; has_own = 1'b1; end
            CH_PLUS:  begin own.kind = TK_OPER; own.code = OP_ADD; has_own = 1'b1; end
            CH_MINUS: begin own.kind = TK_OPER; own.code = OP_SUB; has_own = 1'b1; end
            CH_STAR:  begin own.kind = TK_OPER; own.code = OP_MUL; has_own = 1'b1; end
            CH_SLASH: begin own.kind = TK_OPER; own.code = OP_DIV; has_own = 1'b1; end
            default:  ;
        endcase
    end

    always_comb
    begin
        pend_next = pend_reg;
        act_next  = act_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        hd_next   = hd_reg;
        if (tok_valid && !tok_stall)
        begin
            cnt_next = cnt_reg - 2'd1;
            hd_next  = 1'b1;
        end
        if (in_valid && !in_stall)
        begin
            cnt_next = 2'd0;
            hd_next  = 1'b0;
            if (digit)
            begin
                pend_next = (acc > (VALUE_W + 5)'(VMAX)) ? VMAX[VALUE_W-1:0]
                                                           : acc[VALUE_W-1:0];
                act_next = 1'b1;
                if (last)
                begin
                    q_next[0] = '{kind: TK_NUM, code: OP_ADD, num: pend_next};
                    q_next[1] = '{kind: TK_END, code: OP_ADD, num: '0};
                    cnt_next  = 2'd2;
                    pend_next = '0;
                    act_next  = 1'b0;
                end
            end
            else
            begin
                // Flush a finished digit run first, then the item's own token.
                if (act_reg)
                begin
                    q_next[0] = '{kind: TK_NUM, code: OP_ADD, num: pend_reg};
                    cnt_next  = 2'd1;
                end
                pend_next = '0;
                act_next  = 1'b0;
                if (has_own || last)
                begin
                    // A final item without a token of its own emits the end marker.
                    if (has_own)
                        q_next[act_reg] = own;
                    else
                        q_next[act_reg] = '{kind: TK_END, code: OP_ADD, num: '0};
                    cnt_next = act_reg ? 2'd2 : 2'd1;
                end
            end
        end
    end

    // A non-digit last item with its own token needs a further token (end);
    // track it with a flag raised on accept and served once the queue drains.
    always_comb
    begin
        end_next = end_reg;
        if (in_valid && !in_stall)
            end_next = last && !digit && has_own;
        else if (end_reg && cnt_reg == 2'd0)
            end_next = 1'b0;
    end

    token_t q0_fin;
    logic [1:0] cnt_fin;
    always_comb
    begin
        q0_fin  = q_next[0];
        cnt_fin = cnt_next;
        if (end_reg && cnt_reg == 2'd0)
        begin
            q0_fin  = '{kind: TK_END, code: OP_ADD, num: '0};
            cnt_fin = 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            act_reg  <= 1'b0;
            cnt_reg  <= 2'd0;
            hd_reg   <= 1'b0;
            end_reg  <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            act_reg  <= act_next;
            cnt_reg  <= cnt_fin;
            hd_reg   <= (end_reg && cnt_reg == 2'd0) ? 1'b0 : hd_next;
            end_reg  <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg[0] <= q0_fin;
        q_reg[1] <= q_next[1];
    end
endmodule

// File: rtl/core/iee_queue.sv
// Short token queue between the front end and the back end.
module iee_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  iee_pkg::token_t wr_tok,
    input  logic            wr_valid,
    output logic            wr_stall,
    output iee_pkg::token_t rd_tok,
    output logic            rd_valid,
    input  logic            rd_stall
);
    import iee_pkg::*;

    localparam int AW = $clog2(DEPTH);
    token_t        mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          wr, rd;

    assign wr_stall = (cnt_reg == (AW + 1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_tok   = mem[rp_reg];
    assign wr = wr_valid && !wr_stall;
    assign rd = rd_valid && !rd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (rd) rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW + 1)'(wr) - (AW + 1)'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) mem[wp_reg] <= wr_tok;
    end
endmodule

// File: rtl/core/iee_back.sv
// Back end: operator and operand stacks with a multicycle ALU.
`include "infix_expression_evaluator_macros.svh"
module iee_back #(
    parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF,
    parameter int FRAC_BITS   = iee_pkg::FRAC_BITS_DEF,
    parameter int INT_BITS    = iee_pkg::INT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  iee_pkg::token_t                   tok,
    input  logic                              tok_valid,
    output logic                              tok_stall,
    output logic signed [iee_pkg::VALUE_W-1:0] value,
    output logic [iee_pkg::STATUS_W-1:0]      status,
    output logic                              out_valid,
    input  logic                              out_stall
);
    import iee_pkg::*;

    localparam int VB  = (INT_BITS + FRAC_BITS > VALUE_W) ? VALUE_W : INT_BITS + FRAC_BITS;
    localparam int SW  = $clog2(STACK_DEPTH);
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int DIVN = VALUE_W + FRAC_BITS;
    localparam int CNTW = $clog2(DIVN + 1);
    localparam logic signed [VALUE_W:0] VMAX = (VALUE_W + 1)'((65'd1 << (VB - 1)) - 65'd1);
    localparam logic signed [VALUE_W:0] VMIN = -VMAX - (VALUE_W + 1)'(1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_POP  = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [LEVEL_W+1:0]        ops [STACK_DEPTH];
    logic signed [VALUE_W-1:0] vals [STACK_DEPTH];
    logic [CW-1:0]             opc_reg, vlc_reg;
    logic [LEVEL_W-1:0]        lvl_reg;
    logic [1:0]                err_reg;
    logic [2:0]                st_reg;
    logic                      hold_reg;     // token held while reducing
    logic                      fin_reg;      // reducing for end of expression
    logic [1:0]                rcode_reg;
    logic signed [VALUE_W-1:0] x_reg, y_reg;
    logic [VALUE_W-1:0]        ma_reg, mb_reg;
    logic                      neg_reg;
    logic [2*VALUE_W-1:0]      prod_reg;
    logic [1:0]                mstep_reg;
    logic [DIVN-1:0]           dq_reg;
    logic [VALUE_W:0]          drem_reg;
    logic [CNTW-1:0]           dcnt_reg;
    logic                      dbig_reg;
    logic [63:0]               qacc_reg;
    logic signed [VALUE_W-1:0] out_v_reg;
    logic [1:0]                out_s_reg;
    logic                      out_vld_reg;

    logic [LEVEL_W+1:0] top_op;
    logic               higher;
    logic               is_oper;

    assign value     = out_v_reg;
    assign status    = out_s_reg;
    assign out_valid = out_vld_reg;
    assign top_op    = ops[SW'(opc_reg - 1'b1)];
    assign is_oper   = tok.kind == TK_OPER;
    assign higher    = (top_op[LEVEL_W+1:2] != lvl_reg) ? (top_op[LEVEL_W+1:2] > lvl_reg)
                     : !(top_op[1:0] < 2'd2 && tok.code >= 2'd2);
    assign tok_stall = (st_reg != S_IDLE) || (tok.kind == TK_END && out_vld_reg)
                       || (is_oper && opc_reg != '0 && higher)
                       || (tok.kind == TK_END && opc_reg != '0);

    function automatic logic signed [VALUE_W-1:0] sat(input logic signed [VALUE_W+1:0] v);
        if (v > (VALUE_W + 2)'(VMAX)) return VMAX[VALUE_W-1:0];
        if (v < (VALUE_W + 2)'(VMIN)) return VMIN[VALUE_W-1:0];
        return v[VALUE_W-1:0];
    endfunction

    function automatic logic signed [VALUE_W-1:0] apply(input logic [63:0] m, input logic n);
        logic [63:0] c;
        logic signed [65:0] s;
        c = (m > 64'h4000_0000_0000_0000) ? 64'h4000_0000_0000_0000 : m;
        s = n ? -$signed({2'b0, c}) : $signed({2'b0, c});
        if (s > 66'(VMAX)) return VMAX[VALUE_W-1:0];
        if (s < 66'(VMIN)) return VMIN[VALUE_W-1:0];
        return s[VALUE_W-1:0];
    endfunction

    // Multiply in 24 x 24 partial products, one per cycle.
    logic [23:0] pa, pb;
    logic [47:0] pprod;
    always_comb
    begin
        pa = mstep_reg[0] ? ma_reg[47:24] : ma_reg[23:0];
        pb = mstep_reg[1] ? mb_reg[47:24] : mb_reg[23:0];
        pprod = 48'(pa) * 48'(pb);
    end

    logic [VALUE_W:0] dtrial;
    assign dtrial = {drem_reg[VALUE_W-1:0], dq_reg[DIVN-1]} - {1'b0, mb_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opc_reg <= '0; vlc_reg <= '0; lvl_reg <= '0; err_reg <= ST_OK;
            st_reg <= S_IDLE; hold_reg <= 1'b0; fin_reg <= 1'b0; out_vld_reg <= 1'b0;
        end
        else
        begin
            if (out_vld_reg && !out_stall) out_vld_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                begin
                    if (tok_valid)
                    begin
                        if (is_oper && opc_reg != '0 && higher)
                            st_reg <= S_POP;
                        else if (tok.kind == TK_END && opc_reg != '0)
                            st_reg <= S_POP;
                        else if (tok.kind == TK_END && !out_vld_reg)
                        begin
                            out_s_reg <= (err_reg != ST_OK) ? err_reg
                                       : (vlc_reg != CW'(1)) ? ST_MALF : ST_OK;
                            out_v_reg <= (err_reg == ST_OK && vlc_reg == CW'(1)) ? vals[0] : '0;
                            out_vld_reg <= 1'b1;
                            opc_reg <= '0; vlc_reg <= '0; lvl_reg <= '0; err_reg <= ST_OK;
                        end
                        else if (tok.kind == TK_NUM)
                        begin
                            if (vlc_reg == CW'(STACK_DEPTH))
                            begin
                                if (err_reg == ST_OK) err_reg <= ST_OVFL;
                            end
                            else
                            begin
                                vals[SW'(vlc_reg)] <= tok.num;
                                vlc_reg <= vlc_reg + 1'b1;
                            end
                        end
                        else if (tok.kind == TK_OPEN)
                        begin
                            if (lvl_reg == '1) begin if (err_reg == ST_OK) err_reg <= ST_OVFL; end
                            else lvl_reg <= lvl_reg + 1'b1;
                        end
                        else if (tok.kind == TK_CLOSE)
                        begin
                            if (lvl_reg == '0) begin if (err_reg == ST_OK) err_reg <= ST_MALF; end
                            else lvl_reg <= lvl_reg - 1'b1;
                        end
                        else if (is_oper)
                        begin
                            if (opc_reg == CW'(STACK_DEPTH))
                            begin
                                if (err_reg == ST_OK) err_reg <= ST_OVFL;
                            end
                            else
                            begin
                                ops[SW'(opc_reg)] <= {lvl_reg, tok.code};
                                opc_reg <= opc_reg + 1'b1;
                            end
                        end
                    end
                end
                S_POP:
                begin
                    rcode_reg <= top_op[1:0];
                    opc_reg <= opc_reg - 1'b1;
                    if (vlc_reg < CW'(2))
                    begin
                        if (err_reg == ST_OK) err_reg <= ST_MALF;
                        st_reg <= S_IDLE;
                    end
                    else
                    begin
                        y_reg <= vals[SW'(vlc_reg - 1'b1)];
                        x_reg <= vals[SW'(vlc_reg - 2'd2)];
                        vlc_reg <= vlc_reg - 1'b1;
                        st_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    ma_reg <= x_reg[VALUE_W-1] ? VALUE_W'(-x_reg) : VALUE_W'(x_reg);
                    mb_reg <= y_reg[VALUE_W-1] ? VALUE_W'(-y_reg) : VALUE_W'(y_reg);
                    neg_reg <= x_reg[VALUE_W-1] ^ y_reg[VALUE_W-1];
                    prod_reg <= '0; mstep_reg <= 2'd0;
                    dcnt_reg <= '0; drem_reg <= '0; dbig_reg <= 1'b0; qacc_reg <= '0;
                    dq_reg <= DIVN'({x_reg[VALUE_W-1] ? VALUE_W'(-x_reg) : VALUE_W'(x_reg)})
                              << FRAC_BITS;
                    unique case (rcode_reg)
                        OP_ADD: begin vals[SW'(vlc_reg - 1'b1)] <= sat(
                                    (VALUE_W + 2)'(x_reg) + (VALUE_W + 2)'(y_reg));
                                    st_reg <= S_IDLE; end
                        OP_SUB: begin vals[SW'(vlc_reg - 1'b1)] <= sat(
                                    (VALUE_W + 2)'(x_reg) - (VALUE_W + 2)'(y_reg));
                                    st_reg <= S_IDLE; end
                        OP_MUL: st_reg <= S_MUL;
                        OP_DIV:
                        begin
                            if (y_reg == '0)
                            begin
                                if (err_reg == ST_OK) err_reg <= ST_DIV0;
                                vals[SW'(vlc_reg - 1'b1)] <= '0;
                                st_reg <= S_IDLE;
                            end
                            else st_reg <= S_DIV;
                        end
                    endcase
                end
                S_MUL:
                begin
                    logic [2*VALUE_W-1:0] pp;
                    logic [2*VALUE_W-1:0] sh;
                    pp = (2 * VALUE_W)'(pprod)
                         << (24 * (32'(mstep_reg[0]) + 32'(mstep_reg[1])));
                    prod_reg <= prod_reg + pp;
                    mstep_reg <= mstep_reg + 1'b1;
                    if (mstep_reg == 2'd3)
                    begin
                        sh = (prod_reg + pp) >> FRAC_BITS;
                        vals[SW'(vlc_reg - 1'b1)] <= apply(
                            (sh[2*VALUE_W-1:63] != '0) ? 64'h4000_0000_0000_0000 : 64'(sh),
                            neg_reg);
                        st_reg <= S_IDLE;
                    end
                end
                S_DIV:
                begin
                    // Restoring division, one quotient bit per cycle.
                    logic qb;
                    qb = !dtrial[VALUE_W];
                    drem_reg <= qb ? dtrial : {drem_reg[VALUE_W-1:0], dq_reg[DIVN-1]};
                    dq_reg <= dq_reg << 1;
                    if (!dbig_reg)
                    begin
                        if (qacc_reg[63:62] != 2'b0) dbig_reg <= 1'b1;
                        else qacc_reg <= {qacc_reg[62:0], qb};
                    end
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == CNTW'(DIVN - 1))
                    begin
                        vals[SW'(vlc_reg - 1'b1)] <= apply(
                            (dbig_reg || qacc_reg[63:62] != 2'b0)
                                ? 64'h4000_0000_0000_0000 : {qacc_reg[62:0], qb}, neg_reg);
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    `IEE_ASSERT_IMPL(a_opc_bound, 1'b1, opc_reg <= CW'(STACK_DEPTH), "operator count past depth")
    `IEE_ASSERT_IMPL(a_vlc_bound, 1'b1, vlc_reg <= CW'(STACK_DEPTH), "operand count past depth")
    `IEE_ASSERT_NEXT(a_pop_next, st_reg == S_POP, st_reg == S_IDLE || st_reg == S_EXEC,
                     "pop left to wrong state")
endmodule

// File: rtl/core/infix_expression_evaluator.sv
// Top level of the streaming infix expression evaluator.
//
// Takes an arithmetic expression one character per item (ch, last) and
// returns one result item (value in signed fixed point, status) after the
// item marked last. Digits, + - * / and parentheses are recognized; other
// characters only end a digit run. The front end turns characters into
// tokens: it accumulates digits, hands on each finished number, operator or
// parenthesis and the end marker, and inserts the end marker behind a final
// operator or parenthesis. A four-entry token queue feeds the back end,
// which keeps the operator and operand stacks. The back end takes a
// number, parenthesis or operator token while idle; each reduction pops an
// operator and two operands, then adds or subtracts, multiplies from four
// 24x24 partial products, or divides (one quotient bit per cycle). The final
// item drains all stacked operators before the result.
// Status: 0 ok, 1 malformed or underflow, 2 stack or nesting overflow,
// 3 divide by zero; value is 0 whenever status is nonzero.
module infix_expression_evaluator #(
    parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF,
    parameter int FRAC_BITS   = iee_pkg::FRAC_BITS_DEF,
    parameter int INT_BITS    = iee_pkg::INT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [iee_pkg::CH_W-1:0]           ch,
    input  logic                               last,
    input  logic                               in_valid,
    output logic                               in_stall,
    output logic signed [iee_pkg::VALUE_W-1:0] value,
    output logic [iee_pkg::STATUS_W-1:0]       status,
    output logic                               out_valid,
    input  logic                               out_stall
);
    import iee_pkg::*;

    token_t f_tok, b_tok;
    logic   f_valid, f_stall, b_valid, b_stall;

    // Classify characters and accumulate digit runs.
    iee_front #(.FRAC_BITS(FRAC_BITS), .INT_BITS(INT_BITS)) u_front (
        .clk, .rst_n, .ch, .last, .in_valid, .in_stall,
        .tok(f_tok), .tok_valid(f_valid), .tok_stall(f_stall)
    );

    // Decouple the two halves.
    iee_queue #(.DEPTH(4)) u_queue (
        .clk, .rst_n,
        .wr_tok(f_tok), .wr_valid(f_valid), .wr_stall(f_stall),
        .rd_tok(b_tok), .rd_valid(b_valid), .rd_stall(b_stall)
    );

    // Evaluate tokens on the stacks.
    iee_back #(.STACK_DEPTH(STACK_DEPTH), .FRAC_BITS(FRAC_BITS), .INT_BITS(INT_BITS)) u_back (
        .clk, .rst_n, .tok(b_tok), .tok_valid(b_valid), .tok_stall(b_stall),
        .value, .status, .out_valid, .out_stall
    );
endmodule
